>>> sv/lrs_pkg.sv
// Shared types, codes and saturation helpers for the linear regression trainer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lrs_pkg;

    localparam logic [1:0] MODE_FEAT   = 2'd0;
    localparam logic [1:0] MODE_TARGET = 2'd1;
    localparam logic [1:0] MODE_WEIGHT = 2'd2;
    localparam logic [1:0] MODE_RUN    = 2'd3;

    localparam logic [2:0] CFG_STEP      = 3'd0;
    localparam logic [2:0] CFG_SAMPLES   = 3'd1;
    localparam logic [2:0] CFG_FEATURES  = 3'd2;
    localparam logic [2:0] CFG_THRESHOLD = 3'd3;
    localparam logic [2:0] CFG_LIMIT     = 3'd4;

    localparam logic [31:0] RST_STEP      = 32'd36000;
    localparam logic [6:0]  RST_SAMPLES   = 7'd1;
    localparam logic [2:0]  RST_FEATURES  = 3'd1;
    localparam logic [63:0] RST_THRESHOLD = 64'd429;
    localparam logic [23:0] RST_LIMIT     = 24'd1000000;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_TAKE,
        OP_READ,
        OP_ACC_TGT,
        OP_ACC_PROD,
        OP_ACC_BIAS_W,
        OP_ACC_BIAS_R,
        OP_ACC_CLR,
        OP_MUL_WX,
        OP_MUL_RX,
        OP_RES_WR,
        OP_RES_SQ,
        OP_SUM_CLR,
        OP_SUM_SQ,
        OP_STEP_MUL,
        OP_W_UPD,
        OP_DIV,
        OP_FINISH,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic out_busy;
        logic sel;
    } t_stat;

    // signed 128-bit value saturated into signed 64 bits
    function automatic logic [63:0] sat64(input logic [127:0] x);
        logic [63:0] y;
        if (x[127:63] == {65{x[63]}}) begin
            y = x[63:0];
        end else if (x[127]) begin
            y = 64'h8000_0000_0000_0000;
        end else begin
            y = 64'h7fff_ffff_ffff_ffff;
        end
        return y;
    endfunction

    // a - b on signed 64-bit values, saturated
    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] d;
        logic [63:0] y;
        d = {a[63], a} - {b[63], b};
        if (d[64] == d[63]) begin
            y = d[63:0];
        end else if (d[64]) begin
            y = 64'h8000_0000_0000_0000;
        end else begin
            y = 64'h7fff_ffff_ffff_ffff;
        end
        return y;
    endfunction

endpackage
`default_nettype wire

>>> sv/lrs_mul.sv
// Sequential signed 64x64 multiplier, one 32x32 partial product per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module lrs_mul (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic              o_done,
    output logic [127:0]      o_prod
);
    logic [63:0]  r_ma, r_mb;
    logic         r_neg, r_busy, r_done;
    logic [2:0]   r_k;
    logic [127:0] r_acc, r_p;
    logic [31:0]  pa, pb;
    logic [63:0]  part;
    logic [127:0] part_sh;

    always_comb begin
        pa = r_k[1] ? r_ma[63:32] : r_ma[31:0];
        pb = r_k[0] ? r_mb[63:32] : r_mb[31:0];
        part = pa * pb;
        unique case ({r_k[1], r_k[0]})
            2'b00:   part_sh = {64'd0, part};
            2'b11:   part_sh = {part, 64'd0};
            default: part_sh = {32'd0, part, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_k == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[63] ? (64'd0 - i_a) : i_a;
            r_mb  <= i_b[63] ? (64'd0 - i_b) : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_k == 3'd4) begin
                r_p <= r_neg ? (128'd0 - r_acc) : r_acc;
            end else begin
                r_acc <= r_acc + part_sh;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule
`default_nettype wire

>>> sv/lrs_div.sv
// Restoring divider, 128-bit dividend by a small unsigned divisor, one bit a cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module lrs_div #(
    parameter int DW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [127:0]  i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [127:0]       o_quot
);
    logic [127:0]  r_q;
    logic [DW-1:0] r_rem, r_den;
    logic [6:0]    r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   trial;
    logic          qbit;

    always_comb begin
        trial = {r_rem, r_q[127]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[126:0], qbit};
            r_rem <= qbit ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

>>> sv/lrs_dp.sv
// Datapath: sample stores, weights, accumulators, output register, config registers.
// Depends on lrs_pkg, lrs_mul and lrs_div.
`timescale 1ns / 1ps
`default_nettype none
module lrs_dp
    import lrs_pkg::*;
#(
    parameter int MAX_SAMPLES  = 64,
    parameter int MAX_FEATURES = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    input  wire logic [((($clog2(MAX_SAMPLES + 1)) > 7) ? $clog2(MAX_SAMPLES + 1) : 7)-1:0] i_s,
    input  wire logic [$clog2(MAX_FEATURES + 1)-1:0] i_f,
    output t_stat                         o_stat,
    output logic [((($clog2(MAX_SAMPLES + 1)) > 7) ? $clog2(MAX_SAMPLES + 1) : 7)-1:0] o_n,
    output logic [$clog2(MAX_FEATURES + 1)-1:0] o_fc,
    input  wire logic [1:0]               i_mode,
    input  wire logic [5:0]               i_sample_index,
    input  wire logic [2:0]               i_feature_index,
    input  wire logic signed [31:0]       i_load_value,
    input  wire logic [63:0]              i_batch_mask,
    input  wire logic                     i_cfg_we,
    input  wire logic [2:0]               i_cfg_index,
    input  wire logic [63:0]              i_cfg_data,
    input  wire logic                     i_stall,
    output logic                          o_valid,
    output logic [2:0]                    o_weight_index,
    output logic signed [63:0]            o_weight_value,
    output logic [63:0]                   o_mean_sq_error,
    output logic [23:0]                   o_epoch_number,
    output logic                          o_stop,
    output logic                          o_last
);
    localparam int CW  = ($clog2(MAX_SAMPLES + 1) > 7) ? $clog2(MAX_SAMPLES + 1) : 7;
    localparam int FW  = $clog2(MAX_FEATURES + 1);
    localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int FDEPTH = MAX_SAMPLES * (2 ** FW);

    // configuration
    logic [31:0] r_step;
    logic [6:0]  r_samples;
    logic [2:0]  r_features;
    logic [63:0] r_thresh;
    logic [23:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= RST_STEP;
            r_samples  <= RST_SAMPLES;
            r_features <= RST_FEATURES;
            r_thresh   <= RST_THRESHOLD;
            r_limit    <= RST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEP:      r_step     <= i_cfg_data[31:0];
                CFG_SAMPLES:   r_samples  <= i_cfg_data[6:0];
                CFG_FEATURES:  r_features <= i_cfg_data[2:0];
                CFG_THRESHOLD: r_thresh   <= i_cfg_data;
                CFG_LIMIT:     r_limit    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_samples == 7'd0) begin
            o_n = CW'(1);
        end else if (32'(r_samples) > MAX_SAMPLES) begin
            o_n = CW'(MAX_SAMPLES);
        end else begin
            o_n = CW'(r_samples);
        end
        if (r_features == 3'd0) begin
            o_fc = FW'(1);
        end else if (32'(r_features) > MAX_FEATURES) begin
            o_fc = FW'(MAX_FEATURES);
        end else begin
            o_fc = FW'(r_features);
        end
    end

    logic take;
    assign take = (i_cmd.op == OP_TAKE);

    // batch mask; an empty batch falls back to sample 0
    logic [63:0] r_mask, low_mask;
    always_comb begin
        for (int j = 0; j < 64; j++) begin
            low_mask[j] = (32'(o_n) > j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_mode == MODE_RUN) begin
            r_mask <= (|(i_batch_mask & low_mask)) ? i_batch_mask : 64'd1;
        end
    end

    // stores
    logic [31:0] r_feat_mem [FDEPTH];
    logic [31:0] r_tgt_mem  [MAX_SAMPLES];
    logic [63:0] r_res_mem  [MAX_SAMPLES];
    logic [31:0] r_x, r_y;
    logic [63:0] r_rd;
    logic [SAW-1:0] rd_s, wr_s;
    logic [63:0] res_now;
    logic signed [127:0] r_acc;

    assign rd_s    = SAW'(i_s);
    assign wr_s    = SAW'(i_sample_index);
    assign res_now = sat64(r_acc >>> 16);

    always_ff @(posedge i_clk) begin
        if (take && i_mode == MODE_FEAT && 32'(i_sample_index) < MAX_SAMPLES
                && 32'(i_feature_index) < MAX_FEATURES) begin
            r_feat_mem[{wr_s, FW'(i_feature_index)}] <= i_load_value;
        end
        if (i_cmd.op == OP_READ) begin
            r_x <= r_feat_mem[{rd_s, i_f}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_mode == MODE_TARGET && 32'(i_sample_index) < MAX_SAMPLES) begin
            r_tgt_mem[wr_s] <= i_load_value;
        end
        if (i_cmd.op == OP_READ) begin
            r_y <= r_tgt_mem[rd_s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RES_WR) begin
            r_res_mem[rd_s] <= res_now;
        end
        if (i_cmd.op == OP_READ) begin
            r_rd <= r_res_mem[rd_s];
        end
    end

    // multiplier and divider
    logic         mul_start, mul_done, div_done;
    logic [63:0]  mul_a, mul_b, w_cur, x_ext;
    logic [127:0] mul_p, div_q;
    logic [63:0]  r_w [MAX_FEATURES + 1];
    logic [127:0] r_sum;

    assign w_cur = r_w[i_f];
    assign x_ext = {{32{r_x[31]}}, r_x};

    always_comb begin
        mul_start = 1'b1;
        mul_a     = w_cur;
        mul_b     = x_ext;
        unique case (i_cmd.op)
            OP_MUL_WX: begin
                mul_a = w_cur;
                mul_b = x_ext;
            end
            OP_MUL_RX: begin
                mul_a = r_rd;
                mul_b = x_ext;
            end
            OP_RES_SQ: begin
                mul_a = res_now;
                mul_b = res_now;
            end
            OP_STEP_MUL: begin
                mul_a = res_now;
                mul_b = {32'd0, r_step};
            end
            default: mul_start = 1'b0;
        endcase
    end

    lrs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    lrs_div #(.DW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV),
        .i_num   (r_sum),
        .i_den   (o_n),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // accumulators
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_ACC_TGT:    r_acc <= 128'd0 - ({{96{r_y[31]}}, r_y} << 40);
            OP_ACC_PROD:   r_acc <= r_acc + mul_p;
            OP_ACC_BIAS_W: r_acc <= r_acc + ({{64{w_cur[63]}}, w_cur} << 16);
            OP_ACC_BIAS_R: r_acc <= r_acc + ({{64{r_rd[63]}}, r_rd} << 16);
            OP_ACC_CLR:    r_acc <= '0;
            default: ;
        endcase
        if (i_cmd.op == OP_SUM_CLR) begin
            r_sum <= '0;
        end else if (i_cmd.op == OP_SUM_SQ) begin
            r_sum <= r_sum + (mul_p >> 48);
        end
    end

    // weights
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MAX_FEATURES; k++) begin
                r_w[k] <= '0;
            end
        end else if (take && i_mode == MODE_WEIGHT && 32'(i_feature_index) <= MAX_FEATURES) begin
            r_w[FW'(i_feature_index)] <= {{8{i_load_value[31]}}, i_load_value, 24'd0};
        end else if (i_cmd.op == OP_W_UPD) begin
            r_w[i_f] <= sat_sub(w_cur, sat64($signed(mul_p) >>> 32));
        end
    end

    // epoch result
    logic [63:0] r_mse, mse_n;
    logic [23:0] r_epoch, epoch_n;
    logic        r_stop;

    assign mse_n   = (|div_q[127:64]) ? '1 : div_q[63:0];
    assign epoch_n = (r_epoch != '1) ? r_epoch + 24'd1 : r_epoch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= '0;
        end else if (i_cmd.op == OP_FINISH) begin
            r_epoch <= epoch_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FINISH) begin
            r_mse  <= mse_n;
            r_stop <= (mse_n < r_thresh) || (epoch_n >= r_limit);
        end
    end

    // output register
    logic r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            o_weight_index  <= 3'(i_f);
            o_weight_value  <= w_cur;
            o_mean_sq_error <= r_mse;
            o_epoch_number  <= r_epoch;
            o_stop          <= r_stop;
            o_last          <= (i_f == o_fc);
        end
    end

    assign o_valid = r_valid;

    always_comb begin
        o_stat.mul_done = mul_done;
        o_stat.div_done = div_done;
        o_stat.out_busy = r_valid && i_stall;
        o_stat.sel      = (32'(i_s) < 64) && r_mask[i_s[5:0]];
    end
endmodule
`default_nettype wire

>>> sv/lrs_ctrl.sv
// Controller: sequences loads and the residual, gradient, error and report passes.
// Depends on lrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lrs_ctrl
    import lrs_pkg::*;
#(
    parameter int MAX_SAMPLES  = 64,
    parameter int MAX_FEATURES = 7
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_mode,
    output logic             o_stall,
    input  wire t_stat       i_stat,
    input  wire logic [((($clog2(MAX_SAMPLES + 1)) > 7) ? $clog2(MAX_SAMPLES + 1) : 7)-1:0] i_n,
    input  wire logic [$clog2(MAX_FEATURES + 1)-1:0] i_fc,
    output t_cmd             o_cmd,
    output logic [((($clog2(MAX_SAMPLES + 1)) > 7) ? $clog2(MAX_SAMPLES + 1) : 7)-1:0] o_s,
    output logic [$clog2(MAX_FEATURES + 1)-1:0] o_f
);
    localparam int CW = ($clog2(MAX_SAMPLES + 1) > 7) ? $clog2(MAX_SAMPLES + 1) : 7;
    localparam int FW = $clog2(MAX_FEATURES + 1);

    typedef enum logic [18:0] {
        ST_IDLE    = 19'h00001,
        ST_SCAN    = 19'h00002,
        ST_TGT     = 19'h00004,
        ST_FRD     = 19'h00008,
        ST_MSTART  = 19'h00010,
        ST_MWAIT   = 19'h00020,
        ST_RES     = 19'h00040,
        ST_EWAIT   = 19'h00080,
        ST_GF      = 19'h00100,
        ST_GSCAN   = 19'h00200,
        ST_GMSTART = 19'h00400,
        ST_GMWAIT  = 19'h00800,
        ST_GSAT    = 19'h01000,
        ST_GSWAIT  = 19'h02000,
        ST_DWAIT   = 19'h04000,
        ST_OUT     = 19'h08000,
        ST_SPARE0  = 19'h10000,
        ST_SPARE1  = 19'h20000,
        ST_SPARE2  = 19'h40000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_s, n_s;
    logic [FW:0]   r_f, n_f;
    logic          r_eph, n_eph;
    logic [FW:0]   fc_x;

    assign fc_x = {1'b0, i_fc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_s     <= '0;
            r_f     <= '0;
            r_eph   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s     <= n_s;
            r_f     <= n_f;
            r_eph   <= n_eph;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_s      = r_s;
        n_f      = r_f;
        n_eph    = r_eph;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_TAKE;
                    if (i_mode == MODE_RUN) begin
                        n_s     = '0;
                        n_eph   = 1'b0;
                        n_state = ST_SCAN;
                    end
                end
            end
            // sample walk shared by the residual and error passes
            ST_SCAN: begin
                if (r_s == i_n) begin
                    if (!r_eph) begin
                        n_f     = '0;
                        n_state = ST_GF;
                    end else begin
                        o_cmd.op = OP_DIV;
                        n_state  = ST_DWAIT;
                    end
                end else if (!r_eph && !i_stat.sel) begin
                    n_s = r_s + CW'(1);
                end else begin
                    o_cmd.op = OP_READ;
                    n_state  = ST_TGT;
                end
            end
            ST_TGT: begin
                o_cmd.op = OP_ACC_TGT;
                n_f      = '0;
                n_state  = ST_FRD;
            end
            ST_FRD: begin
                if (r_f == fc_x) begin
                    o_cmd.op = OP_ACC_BIAS_W;
                    n_state  = ST_RES;
                end else begin
                    o_cmd.op = OP_READ;
                    n_state  = ST_MSTART;
                end
            end
            ST_MSTART: begin
                o_cmd.op = OP_MUL_WX;
                n_state  = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = OP_ACC_PROD;
                    n_f      = r_f + (FW+1)'(1);
                    n_state  = ST_FRD;
                end
            end
            ST_RES: begin
                if (!r_eph) begin
                    o_cmd.op = OP_RES_WR;
                    n_s      = r_s + CW'(1);
                    n_state  = ST_SCAN;
                end else begin
                    o_cmd.op = OP_RES_SQ;
                    n_state  = ST_EWAIT;
                end
            end
            ST_EWAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = OP_SUM_SQ;
                    n_s      = r_s + CW'(1);
                    n_state  = ST_SCAN;
                end
            end
            // gradient and update, one weight at a time
            ST_GF: begin
                n_s = '0;
                if (r_f > fc_x) begin
                    o_cmd.op = OP_SUM_CLR;
                    n_eph    = 1'b1;
                    n_state  = ST_SCAN;
                end else begin
                    o_cmd.op = OP_ACC_CLR;
                    n_state  = ST_GSCAN;
                end
            end
            ST_GSCAN: begin
                if (r_s == i_n) begin
                    n_state = ST_GSAT;
                end else if (!i_stat.sel) begin
                    n_s = r_s + CW'(1);
                end else begin
                    o_cmd.op = OP_READ;
                    n_state  = ST_GMSTART;
                end
            end
            ST_GMSTART: begin
                if (r_f == fc_x) begin
                    o_cmd.op = OP_ACC_BIAS_R;
                    n_s      = r_s + CW'(1);
                    n_state  = ST_GSCAN;
                end else begin
                    o_cmd.op = OP_MUL_RX;
                    n_state  = ST_GMWAIT;
                end
            end
            ST_GMWAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = OP_ACC_PROD;
                    n_s      = r_s + CW'(1);
                    n_state  = ST_GSCAN;
                end
            end
            ST_GSAT: begin
                o_cmd.op = OP_STEP_MUL;
                n_state  = ST_GSWAIT;
            end
            ST_GSWAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.op = OP_W_UPD;
                    n_f      = r_f + (FW+1)'(1);
                    n_state  = ST_GF;
                end
            end
            ST_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_FINISH;
                    n_f      = '0;
                    n_state  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_EMIT;
                    if (r_f == fc_x) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_f = r_f + (FW+1)'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_s     = r_s;
    assign o_f     = r_f[FW-1:0];
endmodule
`default_nettype wire

>>> sv/linear_regression_sgd_engine.sv
// Linear regression trainer, mini-batch gradient descent in fixed point.
// Input channel (i_valid / o_stall) carries loads and epoch runs; load modes
// write a feature, target or initial weight and give no result.
// A run item (mode 3) walks the batch for residuals, forms each gradient,
// updates the Q24.40 weights, recomputes the error over all samples, then
// reports feature_count + 1 results (bias last, o_last set) on o_valid / i_stall.
// Multiplies run on the single shared 64x64 multiplier (4 partial products);
// the mean divide is bit-serial.
// Items are taken one at a time; o_stall stays high until the last result of
// an epoch sits in the output register. A stalled output holds the walk at
// the report step. Reset restores the config defaults, zeroes the weights
// and the epoch count; feature and target stores are undefined until written.
// Config writes (i_cfg_valid, always ready) must be made while the block is
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module linear_regression_sgd_engine
    import lrs_pkg::*;
#(
    parameter int MAX_SAMPLES  = 64,
    parameter int MAX_FEATURES = 7
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_mode,
    input  wire logic [5:0]         i_sample_index,
    input  wire logic [2:0]         i_feature_index,
    input  wire logic signed [31:0] i_load_value,
    input  wire logic [63:0]        i_batch_mask,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_weight_index,
    output logic signed [63:0]      o_weight_value,
    output logic [63:0]             o_mean_sq_error,
    output logic [23:0]             o_epoch_number,
    output logic                    o_stop,
    output logic                    o_last,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data
);
    localparam int CW = ($clog2(MAX_SAMPLES + 1) > 7) ? $clog2(MAX_SAMPLES + 1) : 7;
    localparam int FW = $clog2(MAX_FEATURES + 1);

    t_cmd          cmd;
    t_stat         stat;
    logic [CW-1:0] s_idx, n_used;
    logic [FW-1:0] f_idx, fc_used;

    assign o_cfg_ready = 1'b1;

    lrs_ctrl #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_stall (o_stall),
        .i_stat  (stat),
        .i_n     (n_used),
        .i_fc    (fc_used),
        .o_cmd   (cmd),
        .o_s     (s_idx),
        .o_f     (f_idx)
    );

    lrs_dp #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_s             (s_idx),
        .i_f             (f_idx),
        .o_stat          (stat),
        .o_n             (n_used),
        .o_fc            (fc_used),
        .i_mode          (i_mode),
        .i_sample_index  (i_sample_index),
        .i_feature_index (i_feature_index),
        .i_load_value    (i_load_value),
        .i_batch_mask    (i_batch_mask),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_weight_index  (o_weight_index),
        .o_weight_value  (o_weight_value),
        .o_mean_sq_error (o_mean_sq_error),
        .o_epoch_number  (o_epoch_number),
        .o_stop          (o_stop),
        .o_last          (o_last)
    );
endmodule
`default_nettype wire
